[rtl/dra_pkg.sv]
// Shared constants, types and state encoding for the delayed room allocator.
package dra_pkg;

    localparam int MAX_ROOMS  = 16;
    localparam int COUNT_BITS = 20;
    localparam int TIME_W     = 48;
    localparam int REQ_T_W    = 32;
    localparam int CFG_W      = 5;
    localparam int ROOM_OUT_W = 4;
    localparam int IDX_W      = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ROOMS + 1);

    localparam logic [TIME_W-1:0]     TIME_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_UPDATE
    } t_state;

    // Access request toward the room store.
    typedef struct packed {
        logic                  rd_en;
        logic [IDX_W-1:0]      rd_idx;
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_idx;
        logic [TIME_W-1:0]     wr_busy;
        logic [COUNT_BITS-1:0] wr_cnt;
        logic                  clr;
    } t_mem_req;

    // Registered read data, already forced to zero for entries not written since a clear.
    typedef struct packed {
        logic [TIME_W-1:0]     busy;
        logic [COUNT_BITS-1:0] cnt;
    } t_mem_rsp;

endpackage

[rtl/dra_room_store.sv]
// Per-room busy-until and use-count memories with registered reads and valid bits.
module dra_room_store
    import dra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [TIME_W-1:0]     r_busy_mem [MAX_ROOMS];
    logic [COUNT_BITS-1:0] r_cnt_mem  [MAX_ROOMS];
    logic [MAX_ROOMS-1:0]  r_valid;
    logic [TIME_W-1:0]     r_busy_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_busy_mem[i_req.wr_idx] <= i_req.wr_busy;
            r_cnt_mem[i_req.wr_idx]  <= i_req.wr_cnt;
        end
        if (i_req.rd_en) begin
            r_busy_q <= r_busy_mem[i_req.rd_idx];
            r_cnt_q  <= r_cnt_mem[i_req.rd_idx];
        end
    end

    // A clear drops every valid bit at once; a write marks its entry as holding data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_vld_q <= r_valid[i_req.rd_idx];
            end
        end
    end

    assign o_rsp.busy = r_vld_q ? r_busy_q : '0;
    assign o_rsp.cnt  = r_vld_q ? r_cnt_q  : '0;

endmodule

[rtl/delayed_room_allocator_core.sv]
// Top level of the delayed room allocator: request handshake, room scan and update sequencer.
// Usage. Each request on the slave stream carries one job: tdata holds start_time in
// bits 31:0 and end_time in bits 63:32, and tuser bit 0 is first_in_set, which wipes
// all room state, the running time and the most-booked tracking before the job is
// placed. The job goes to the lowest room whose busy-until time is no later than the
// scheduling time, or else to the lowest room that frees up earliest, in which case
// the job is delayed to that time. One result per request leaves on the master stream.
// The user must write the room count on the separate configuration channel only while the
// block is idle, which it does not enforce; zero counts as one room, over sixteen as sixteen.
//
// Timing. The block works on one request at a time. After a request is taken the
// busy-until memory is read one room per cycle over the N configured rooms, the drain state
// compares the last read data, the decide state settles the choice and reads the use
// count, and the update state writes both memories back and loads the result register.
// No new request is taken until the update has committed and the block is idle again.
//
// Reset clears the sequencer, the output register and all room valid bits, and sets
// the room count to sixteen. When the receiver stalls, the result waits in the output
// register; the next request is still taken and scanned, and only its final update
// waits until the previous result has been taken.
module delayed_room_allocator_core
    import dra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration channel: room count.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Request stream.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,  // start_time[31:0], end_time[63:32]
    input  logic [0:0]       s_axis_tuser,  // first_in_set[0]
    // Result stream.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [55:0]      m_axis_tdata   // assigned_room[3:0], actual_start[51:4],
                                            // most_booked[55:52]
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_room_count;
    logic [CNT_W-1:0]      r_rc;
    logic [REQ_T_W-1:0]    r_dur;
    logic [TIME_W-1:0]     r_t;
    logic [TIME_W-1:0]     r_running;
    logic [CNT_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      r_tag;
    logic                  r_tag_vld;
    logic                  r_found;
    logic [IDX_W-1:0]      r_fpick;
    logic [TIME_W-1:0]     r_min;
    logic [IDX_W-1:0]      r_minidx;
    logic [IDX_W-1:0]      r_pick;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [IDX_W-1:0]      r_best_room;
    logic                  r_out_valid;
    logic [ROOM_OUT_W-1:0] r_out_room;
    logic [TIME_W-1:0]     r_out_start;
    logic [ROOM_OUT_W-1:0] r_out_best;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    logic                  in_fire;
    logic                  req_first;
    logic [REQ_T_W-1:0]    req_start;
    logic [REQ_T_W-1:0]    req_end;
    logic [TIME_W-1:0]     base_time;
    logic [CNT_W-1:0]      req_rc;
    logic                  scan_last;
    logic                  commit;
    logic [IDX_W-1:0]      decide_pick;
    logic [TIME_W:0]       end_sum;
    logic [TIME_W-1:0]     new_busy;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  best_take;

    dra_room_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    assign req_start = s_axis_tdata[31:0];
    assign req_end   = s_axis_tdata[63:32];
    assign req_first = s_axis_tuser[0];
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // A new set starts from time zero; otherwise time never runs backwards.
    assign base_time = req_first ? '0 : r_running;

    always_comb begin
        if (r_room_count == '0) begin
            req_rc = CNT_W'(1);
        end else if (32'(r_room_count) > MAX_ROOMS) begin
            req_rc = CNT_W'(MAX_ROOMS);
        end else begin
            req_rc = CNT_W'(r_room_count);
        end
    end

    assign scan_last   = (r_rd_idx == r_rc - CNT_W'(1));
    assign decide_pick = r_found ? r_fpick : r_minidx;
    assign commit      = (r_state == ST_UPDATE) && (!r_out_valid || m_axis_tready);

    // New busy-until saturates at the top of the time range.
    assign end_sum  = {1'b0, r_t} + (TIME_W + 1)'(r_dur);
    assign new_busy = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    assign new_cnt  = (mem_rsp.cnt == COUNT_MAX) ? mem_rsp.cnt
                                                 : mem_rsp.cnt + COUNT_BITS'(1);
    assign best_take = (new_cnt > r_best_cnt)
                    || ((new_cnt == r_best_cnt) && (r_pick < r_best_room));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and memory accesses.
    always_comb begin
        s_axis_tready  = 1'b0;
        mem_req        = '0;
        mem_req.wr_idx = r_pick;
        mem_req.wr_busy = new_busy;
        mem_req.wr_cnt = new_cnt;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_req.clr   = in_fire && req_first;
            end
            ST_SCAN: begin
                mem_req.rd_en  = 1'b1;
                mem_req.rd_idx = r_rd_idx[IDX_W-1:0];
            end
            ST_DECIDE: begin
                mem_req.rd_en  = 1'b1;
                mem_req.rd_idx = decide_pick;
            end
            ST_UPDATE: begin
                mem_req.wr_en = commit;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state and the running scheduling bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_count <= CFG_W'(16);
            r_running    <= '0;
            r_best_cnt   <= '0;
            r_best_room  <= '0;
            r_tag_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_room_count <= i_cfg_data;
            end
            if (in_fire && req_first) begin
                r_running  <= '0;
                r_best_cnt <= '0;
                r_best_room <= '0;
            end
            r_tag_vld <= (r_state == ST_SCAN);
            if (commit) begin
                r_out_valid <= 1'b1;
                r_running   <= r_t;
                if (best_take) begin
                    r_best_cnt  <= new_cnt;
                    r_best_room <= r_pick;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-request working registers and the result register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rc     <= req_rc;
            r_dur    <= (req_end > req_start) ? req_end - req_start : '0;
            r_t      <= (base_time > TIME_W'(req_start)) ? base_time : TIME_W'(req_start);
            r_rd_idx <= '0;
            r_found  <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_tag    <= r_rd_idx[IDX_W-1:0];
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        // Read data arrives in the cycle after its address: first free room and
        // lowest room with the earliest busy-until are tracked side by side.
        if (r_tag_vld) begin
            if (!r_found && (mem_rsp.busy <= r_t)) begin
                r_found <= 1'b1;
                r_fpick <= r_tag;
            end
            if ((r_tag == '0) || (mem_rsp.busy < r_min)) begin
                r_min    <= mem_rsp.busy;
                r_minidx <= r_tag;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_pick <= decide_pick;
            if (!r_found) begin
                r_t <= r_min;
            end
        end
        if (commit) begin
            r_out_room  <= ROOM_OUT_W'(r_pick);
            r_out_start <= r_t;
            r_out_best  <= best_take ? ROOM_OUT_W'(r_pick) : ROOM_OUT_W'(r_best_room);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_best, r_out_start, r_out_room};

endmodule

[rtl/dra_checker.sv]
// Port-level checker for the delayed room allocator, bound to the top level.
module dra_checker
    import dra_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // A request is worked on until it commits, so no request is taken right after another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in progress");

    // Reset leaves no result pending and the request side open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind delayed_room_allocator_core dra_checker u_dra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
